// ----- hdl/resws_pkg.sv -----
package resws_pkg;

  localparam int MAX_SCAN_DEF = 64;
  localparam int MAX_HITS_DEF = 4096;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_STATS = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_FLOOR  = 3'd0,
    REG_RATIO  = 3'd1,
    REG_SCAN   = 3'd2,
    REG_STEPX  = 3'd3,
    REG_STEPY  = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]       floor_level;
    logic [15:0]       ratio_factor;
    logic [6:0]        scan_length;
    logic signed [1:0] step_x;
    logic signed [1:0] step_y;
    logic [12:0]       image_width;
    logic [12:0]       image_height;
  } cfg_t;

  typedef struct packed {
    logic        ray_begin;
    logic [11:0] start_col;
    logic [11:0] start_row;
    logic [15:0] mag_sample;
    logic        set_end;
  } in_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [11:0] edge_col;
    logic [11:0] edge_row;
    logic [15:0] mag_mean;
    logic [15:0] mag_dev;
    logic [15:0] ratio_mean;
    logic [15:0] ratio_dev;
    logic [12:0] hit_total;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic        edge_hit;
    logic        set_end;
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] mag;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_EVAL
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RDIV,
    B_RWAIT,
    B_ACC,
    B_EOUT,
    B_SET,
    B_MDIV,
    B_MWAIT,
    B_P0,
    B_P1,
    B_SQ,
    B_SQRT,
    B_DDIV,
    B_DWAIT,
    B_SOUT,
    B_NOUT
  } back_state_t;

endpackage

// ----- hdl/resws_fifo.sv -----
module resws_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = resws_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- hdl/resws_div.sv -----
module resws_div #(
  parameter int DND_W = 40,
  parameter int DVS_W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DND_W-1:0] dnd,
  input  logic [DVS_W-1:0] dvs,
  output logic             busy,
  output logic             done,
  output logic [15:0]      quo
);

  localparam int CW = ((DND_W > DVS_W + 16) ? DND_W : DVS_W + 16) + 1;

  logic             busy_r;
  logic             done_r;
  logic [DND_W-1:0] rem_r;
  logic [DVS_W+15:0] d_r;
  logic [15:0]      q_r;
  logic [3:0]       i_r;
  logic             ge;
  logic             sat;

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
  assign ge   = CW'(rem_r) >= CW'(d_r);
  assign sat  = CW'(dnd) >= (CW'(dvs) << 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !sat;
        done_r <= sat;
      end else if (busy_r && i_r == 4'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dnd;
      d_r   <= (DVS_W + 16)'(dvs) << 15;
      i_r   <= 4'd15;
      q_r   <= sat ? 16'hFFFF : 16'h0000;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= DND_W'(CW'(rem_r) - CW'(d_r));
      end
      q_r <= {q_r[14:0], ge};
      d_r <= d_r >> 1;
      i_r <= i_r - 1'b1;
    end
  end

endmodule

// ----- hdl/resws_front.sv -----
module resws_front #(
  parameter int MAX_SCAN = resws_pkg::MAX_SCAN_DEF,
  localparam int SCAN_W = $clog2(MAX_SCAN + 1),
  localparam int SUM_W  = 16 + SCAN_W,
  localparam int NUM_W  = 32 + SCAN_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  resws_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  resws_pkg::in_t    in_data,
  output logic              push,
  output resws_pkg::job_t   job,
  output logic [NUM_W-1:0]  job_num,
  output logic [SUM_W-1:0]  job_sum,
  input  logic              fifo_full
);

  resws_pkg::front_state_t state_r, state_nxt;
  resws_pkg::in_t          item_r;
  logic signed [13:0]      col_r, col_nxt;
  logic signed [13:0]      row_r, row_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SCAN_W-1:0]       cnt_r, cnt_nxt;
  logic [SCAN_W-1:0]       pos_r, pos_nxt;
  logic                    closed_r, closed_nxt;

  logic [SCAN_W-1:0]       eff_len;
  logic                    edge_hit;
  logic                    want_push;
  logic                    advance;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        rhs;
  logic [SUM_W-1:0]        base_sum;
  logic [15+SCAN_W:0]      mag_cnt;
  logic signed [13:0]      ecol;
  logic signed [13:0]      erow;

  assign eff_len = (32'(cfg.scan_length) > 32'(MAX_SCAN)) ? SCAN_W'(MAX_SCAN)
                                                          : SCAN_W'(cfg.scan_length);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    closed_nxt = closed_r;
    edge_hit   = 1'b0;
    if (item_r.ray_begin) begin
      col_nxt    = 14'(item_r.start_col);
      row_nxt    = 14'(item_r.start_row);
      sum_nxt    = '0;
      cnt_nxt    = '0;
      pos_nxt    = '0;
      closed_nxt = 1'b0;
    end
    if (!closed_nxt && pos_nxt >= eff_len) begin
      closed_nxt = 1'b1;
    end
    if (!closed_nxt && (col_nxt[13] || row_nxt[13] ||
        $unsigned(col_nxt) >= {1'b0, cfg.image_width} ||
        $unsigned(row_nxt) >= {1'b0, cfg.image_height})) begin
      closed_nxt = 1'b1;
    end
    ecol     = col_nxt;
    erow     = row_nxt;
    base_sum = sum_nxt;
    mag_cnt  = (16 + SCAN_W)'(item_r.mag_sample) * (16 + SCAN_W)'(cnt_nxt);
    num      = NUM_W'({mag_cnt, 12'h000});
    rhs      = NUM_W'(cfg.ratio_factor) * NUM_W'(sum_nxt);
    if (!closed_nxt) begin
      if (cnt_nxt != '0 && item_r.mag_sample > cfg.floor_level && num >= rhs) begin
        edge_hit   = 1'b1;
        closed_nxt = 1'b1;
      end else begin
        sum_nxt = sum_nxt + SUM_W'(item_r.mag_sample);
        cnt_nxt = cnt_nxt + 1'b1;
        col_nxt = col_nxt + 14'(cfg.step_x);
        row_nxt = row_nxt + 14'(cfg.step_y);
        pos_nxt = pos_nxt + 1'b1;
        if (pos_nxt >= eff_len) begin
          closed_nxt = 1'b1;
        end
      end
    end
    if (item_r.set_end) begin
      closed_nxt = 1'b1;
    end
  end

  assign want_push = edge_hit || item_r.set_end;
  assign advance   = (state_r == resws_pkg::F_EVAL) && !(want_push && fifo_full);
  assign push      = (state_r == resws_pkg::F_EVAL) && want_push && !fifo_full;
  assign in_stall  = (state_r != resws_pkg::F_IDLE);

  always_comb begin
    job.edge_hit = edge_hit;
    job.set_end  = item_r.set_end;
    job.col      = ecol[11:0];
    job.row      = erow[11:0];
    job.mag      = item_r.mag_sample;
    job_num      = num;
    job_sum      = base_sum;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      resws_pkg::F_IDLE: begin
        if (in_valid) begin
          state_nxt = resws_pkg::F_EVAL;
        end
      end
      resws_pkg::F_EVAL: begin
        if (advance) begin
          state_nxt = resws_pkg::F_IDLE;
        end
      end
      default: state_nxt = resws_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= resws_pkg::F_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      pos_r    <= '0;
      closed_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        sum_r    <= sum_nxt;
        cnt_r    <= cnt_nxt;
        pos_r    <= pos_nxt;
        closed_r <= closed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == resws_pkg::F_IDLE && in_valid) begin
      item_r <= in_data;
    end
  end

endmodule

// ----- hdl/resws_back.sv -----
module resws_back #(
  parameter int MAX_SCAN = resws_pkg::MAX_SCAN_DEF,
  parameter int MAX_HITS = resws_pkg::MAX_HITS_DEF,
  localparam int SCAN_W = $clog2(MAX_SCAN + 1),
  localparam int SUM_W  = 16 + SCAN_W,
  localparam int NUM_W  = 32 + SCAN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fifo_empty,
  output logic             pop,
  input  resws_pkg::job_t  job,
  input  logic [NUM_W-1:0] job_num,
  input  logic [SUM_W-1:0] job_sum,
  output logic             out_valid,
  input  logic             out_stall,
  output resws_pkg::out_t  out_data
);

  localparam int HW     = $clog2(MAX_HITS + 1);
  localparam int MACC_W = 16 + HW;
  localparam int SQ_W   = 32 + HW;
  localparam int D_W    = 2 * MACC_W;
  localparam int DND_W  = (NUM_W > D_W) ? NUM_W : D_W;
  localparam int DVS_W  = (SUM_W > HW) ? SUM_W : HW;
  localparam int IT_W   = $clog2(MACC_W);

  resws_pkg::back_state_t state_r, state_nxt;
  resws_pkg::job_t        job_r;
  logic [NUM_W-1:0]       num_r;
  logic [SUM_W-1:0]       sum_r;
  logic [HW-1:0]          hit_r;
  logic [MACC_W-1:0]      macc_r, racc_r;
  logic [SQ_W-1:0]        msq_r, rsq_r;
  logic [15:0]            ratio_r;
  logic                   pass_r;
  logic [15:0]            mmean_r, mdev_r, rmean_r, rdev_r;
  logic [D_W-1:0]         prod_r;
  logic [D_W-1:0]         v_r;
  logic [D_W-1:0]         root_r;
  logic [D_W-1:0]         bit_r;
  logic [IT_W-1:0]        it_r;
  logic                   out_valid_r;
  resws_pkg::out_t        out_r;

  logic                   slot_free;
  logic                   out_load;
  resws_pkg::out_t        out_nxt;
  logic                   div_start;
  logic [DND_W-1:0]       div_dnd;
  logic [DVS_W-1:0]       div_dvs;
  logic                   div_busy;
  logic                   div_done;
  logic [15:0]            div_quo;
  logic [MACC_W-1:0]      acc_sel;
  logic [SQ_W-1:0]        sq_sel;
  logic [D_W-1:0]         asq;
  logic [D_W:0]           trial;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign acc_sel   = pass_r ? racc_r : macc_r;
  assign sq_sel    = pass_r ? rsq_r : msq_r;
  assign trial     = (D_W + 1)'(root_r) + (D_W + 1)'(bit_r);

  resws_div #(
    .DND_W(DND_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dnd   (div_dnd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      resws_pkg::B_IDLE: begin
        if (!fifo_empty) begin
          state_nxt = job.edge_hit ? resws_pkg::B_RDIV : resws_pkg::B_SET;
        end
      end
      resws_pkg::B_RDIV:  state_nxt = resws_pkg::B_RWAIT;
      resws_pkg::B_RWAIT: begin
        if (div_done) begin
          state_nxt = resws_pkg::B_ACC;
        end
      end
      resws_pkg::B_ACC:   state_nxt = resws_pkg::B_EOUT;
      resws_pkg::B_EOUT: begin
        if (slot_free) begin
          state_nxt = job_r.set_end ? resws_pkg::B_SET : resws_pkg::B_IDLE;
        end
      end
      resws_pkg::B_SET: begin
        state_nxt = (hit_r == '0) ? resws_pkg::B_NOUT : resws_pkg::B_MDIV;
      end
      resws_pkg::B_MDIV:  state_nxt = resws_pkg::B_MWAIT;
      resws_pkg::B_MWAIT: begin
        if (div_done) begin
          state_nxt = resws_pkg::B_P0;
        end
      end
      resws_pkg::B_P0:    state_nxt = resws_pkg::B_P1;
      resws_pkg::B_P1:    state_nxt = resws_pkg::B_SQ;
      resws_pkg::B_SQ:    state_nxt = resws_pkg::B_SQRT;
      resws_pkg::B_SQRT: begin
        if (it_r == IT_W'(MACC_W - 1)) begin
          state_nxt = resws_pkg::B_DDIV;
        end
      end
      resws_pkg::B_DDIV:  state_nxt = resws_pkg::B_DWAIT;
      resws_pkg::B_DWAIT: begin
        if (div_done) begin
          state_nxt = pass_r ? resws_pkg::B_SOUT : resws_pkg::B_MDIV;
        end
      end
      resws_pkg::B_SOUT, resws_pkg::B_NOUT: begin
        if (slot_free) begin
          state_nxt = resws_pkg::B_IDLE;
        end
      end
      default: state_nxt = resws_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    div_dnd   = DND_W'(num_r);
    div_dvs   = DVS_W'(sum_r);
    out_load  = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      resws_pkg::B_IDLE: pop = !fifo_empty;
      resws_pkg::B_RDIV: div_start = 1'b1;
      resws_pkg::B_MDIV: begin
        div_start = 1'b1;
        div_dnd   = DND_W'(acc_sel);
        div_dvs   = DVS_W'(hit_r);
      end
      resws_pkg::B_DDIV: begin
        div_start = 1'b1;
        div_dnd   = DND_W'(root_r);
        div_dvs   = DVS_W'(hit_r);
      end
      resws_pkg::B_EOUT: begin
        out_load            = slot_free;
        out_nxt.result_kind = resws_pkg::KIND_EDGE;
        out_nxt.edge_col    = job_r.col;
        out_nxt.edge_row    = job_r.row;
        out_nxt.hit_total   = 13'(hit_r);
        out_nxt.last_result = !job_r.set_end;
      end
      resws_pkg::B_SOUT: begin
        out_load            = slot_free;
        out_nxt.result_kind = resws_pkg::KIND_STATS;
        out_nxt.mag_mean    = mmean_r;
        out_nxt.mag_dev     = mdev_r;
        out_nxt.ratio_mean  = rmean_r;
        out_nxt.ratio_dev   = rdev_r;
        out_nxt.hit_total   = 13'(hit_r);
        out_nxt.last_result = 1'b1;
      end
      resws_pkg::B_NOUT: begin
        out_load            = slot_free;
        out_nxt.result_kind = resws_pkg::KIND_NONE;
        out_nxt.last_result = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= resws_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= '0;
      macc_r      <= '0;
      racc_r      <= '0;
      msq_r       <= '0;
      rsq_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == resws_pkg::B_ACC && hit_r < HW'(MAX_HITS)) begin
        hit_r  <= hit_r + 1'b1;
        macc_r <= macc_r + MACC_W'(job_r.mag);
        racc_r <= racc_r + MACC_W'(ratio_r);
        msq_r  <= msq_r + SQ_W'(32'(job_r.mag) * 32'(job_r.mag));
        rsq_r  <= rsq_r + SQ_W'(32'(ratio_r) * 32'(ratio_r));
      end
      if ((state_r == resws_pkg::B_SOUT || state_r == resws_pkg::B_NOUT) && slot_free) begin
        hit_r  <= '0;
        macc_r <= '0;
        racc_r <= '0;
        msq_r  <= '0;
        rsq_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (pop) begin
      job_r <= job;
      num_r <= job_num;
      sum_r <= job_sum;
    end
    if (state_r == resws_pkg::B_RWAIT && div_done) begin
      ratio_r <= div_quo;
    end
    if (state_r == resws_pkg::B_SET) begin
      pass_r <= 1'b0;
    end
    if (state_r == resws_pkg::B_MWAIT && div_done) begin
      if (pass_r) begin
        rmean_r <= div_quo;
      end else begin
        mmean_r <= div_quo;
      end
    end
    if (state_r == resws_pkg::B_P0) begin
      prod_r <= D_W'(hit_r) * D_W'(sq_sel[31:0]);
    end
    if (state_r == resws_pkg::B_P1) begin
      prod_r <= prod_r + ((D_W'(hit_r) * D_W'(sq_sel[SQ_W-1:32])) << 32);
    end
    if (state_r == resws_pkg::B_SQ) begin
      v_r    <= (prod_r > asq) ? prod_r - asq : '0;
      root_r <= '0;
      bit_r  <= D_W'(1) << (D_W - 2);
      it_r   <= '0;
    end
    if (state_r == resws_pkg::B_SQRT) begin
      if ((D_W + 1)'(v_r) >= trial) begin
        v_r    <= D_W'((D_W + 1)'(v_r) - trial);
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
      it_r  <= it_r + 1'b1;
    end
    if (state_r == resws_pkg::B_DWAIT && div_done) begin
      if (pass_r) begin
        rdev_r <= div_quo;
      end else begin
        mdev_r <= div_quo;
        pass_r <= 1'b1;
      end
    end
  end

  assign asq = D_W'(acc_sel) * D_W'(acc_sel);

  assert property (@(posedge clk) disable iff (!rst_n) hit_r <= HW'(MAX_HITS))
    else $error("Hit count exceeds its limit.");

  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
    else $error("Divider started while busy.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == resws_pkg::B_EOUT && slot_free) |=>
      (out_valid && out_data.result_kind == resws_pkg::KIND_EDGE))
    else $error("Edge beat not presented.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == resws_pkg::B_SQRT) |-> (bit_r != '0))
    else $error("Square root ran past its last step.");

endmodule

// ----- hdl/ray_edge_scan_with_stats_top.sv -----
// Front end: each input beat is captured, then classified; in_stall is high while it is classified,
// and a push that meets a full queue holds the classify step. Back end: each edge point runs the
// ratio through the 16-step divider (cut short when the ratio saturates) before its edge beat.
// Set statistics: from the pop, each pass runs a mean division, the bit-serial square root and a
// deviation division on sums sized by HW = clog2(MAX_HITS + 1); a two-entry queue lets the front run ahead.
// Reset (rst_n low, synchronous) restores default registers, closes the ray and clears the sums.
module ray_edge_scan_with_stats_top #(
  parameter int MAX_SCAN = resws_pkg::MAX_SCAN_DEF,
  parameter int MAX_HITS = resws_pkg::MAX_HITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  resws_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output resws_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  localparam int SCAN_W = $clog2(MAX_SCAN + 1);
  localparam int SUM_W  = 16 + SCAN_W;
  localparam int NUM_W  = 32 + SCAN_W;
  localparam int JOB_W  = $bits(resws_pkg::job_t) + NUM_W + SUM_W;

  resws_pkg::cfg_t  cfg_r;
  resws_pkg::job_t  f_job, b_job;
  logic [NUM_W-1:0] f_num, b_num;
  logic [SUM_W-1:0] f_sum, b_sum;
  logic             push, pop, full, empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_level  <= 16'd0;
      cfg_r.ratio_factor <= 16'd4096;
      cfg_r.scan_length  <= 7'd8;
      cfg_r.step_x       <= 2'sd1;
      cfg_r.step_y       <= 2'sd0;
      cfg_r.image_width  <= 13'd1024;
      cfg_r.image_height <= 13'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (resws_pkg::reg_idx_t'(cfg_index))
        resws_pkg::REG_FLOOR:  cfg_r.floor_level  <= cfg_data;
        resws_pkg::REG_RATIO:  cfg_r.ratio_factor <= cfg_data;
        resws_pkg::REG_SCAN:   cfg_r.scan_length  <= cfg_data[6:0];
        resws_pkg::REG_STEPX:  cfg_r.step_x       <= cfg_data[1:0];
        resws_pkg::REG_STEPY:  cfg_r.step_y       <= cfg_data[1:0];
        resws_pkg::REG_WIDTH:  cfg_r.image_width  <= cfg_data[12:0];
        resws_pkg::REG_HEIGHT: cfg_r.image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  resws_front #(
    .MAX_SCAN(MAX_SCAN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .job       (f_job),
    .job_num   (f_num),
    .job_sum   (f_sum),
    .fifo_full (full)
  );

  resws_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(resws_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_job, f_num, f_sum}),
    .pop   (pop),
    .rdata ({b_job, b_num, b_sum}),
    .full  (full),
    .empty (empty)
  );

  resws_back #(
    .MAX_SCAN(MAX_SCAN),
    .MAX_HITS(MAX_HITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (empty),
    .pop        (pop),
    .job        (b_job),
    .job_num    (b_num),
    .job_sum    (b_sum),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
